[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker of this project
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk and disabled in reset
`define BRB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk and disabled in reset
`define BRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/brb_pkg.sv]
// ----------------------------------------------------------------------------
// brb_pkg
// Types and constants of the circular byte fifo
// ----------------------------------------------------------------------------
package brb_pkg;

    // store geometry and field widths
    localparam int BRB_DEPTH  = 4096;
    localparam int BRB_PTR_W  = $clog2(BRB_DEPTH);
    localparam int BRB_LEN_W  = 12;
    localparam int BRB_CW_W   = 13;
    localparam int BRB_BYTE_W = 8;
    localparam logic [7:0] BRB_FILL = 8'h20;

    // action codes
    localparam logic [2:0] ACT_ENQ     = 3'd0;
    localparam logic [2:0] ACT_DEQ     = 3'd1;
    localparam logic [2:0] ACT_PEEK    = 3'd2;
    localparam logic [2:0] ACT_MOVE_RD = 3'd3;
    localparam logic [2:0] ACT_MOVE_WR = 3'd4;
    localparam logic [2:0] ACT_CLEAR   = 3'd5;
    localparam logic [2:0] ACT_QUERY   = 3'd6;

    // controller states
    typedef enum logic [2:0] {
        ST_WIPE,
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_OUT
    } brb_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic in_take;
        logic wipe_en;
        logic rd_en;
        logic out_take;
    } brb_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic burst_start;
        logic clear_req;
        logic wipe_done;
        logic burst_more;
    } brb_stat_t;

endpackage

[sv/brb_ram.sv]
// ----------------------------------------------------------------------------
// brb_ram
// Generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/brb_ctrl.sv]
// ----------------------------------------------------------------------------
// brb_ctrl
// Controller: sequences wipe sweeps, burst reads and result beats
// ----------------------------------------------------------------------------
module brb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  brb_pkg::brb_stat_t stat,
    output brb_pkg::brb_cmd_t  cmd
);

    brb_pkg::brb_state_t state_reg;
    brb_pkg::brb_state_t state_next;

    // state register, reset starts the fill sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brb_pkg::ST_WIPE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            brb_pkg::ST_WIPE:
            begin
                if (stat.wipe_done)
                begin
                    state_next = brb_pkg::ST_IDLE;
                end
            end
            brb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (stat.clear_req)
                    begin
                        state_next = brb_pkg::ST_CLEAR;
                    end
                    else if (stat.burst_start)
                    begin
                        state_next = brb_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = brb_pkg::ST_OUT;
                    end
                end
            end
            brb_pkg::ST_CLEAR:
            begin
                if (stat.wipe_done)
                begin
                    state_next = brb_pkg::ST_OUT;
                end
            end
            brb_pkg::ST_READ:
            begin
                state_next = brb_pkg::ST_OUT;
            end
            brb_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = stat.burst_more ? brb_pkg::ST_READ : brb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = brb_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath commands
    always_comb
    begin
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        cmd.wipe_en  = 1'b0;
        cmd.rd_en    = 1'b0;
        case (state_reg)
            brb_pkg::ST_WIPE:  cmd.wipe_en = 1'b1;
            brb_pkg::ST_IDLE:  in_ready    = 1'b1;
            brb_pkg::ST_CLEAR: cmd.wipe_en = 1'b1;
            brb_pkg::ST_READ:  cmd.rd_en   = 1'b1;
            brb_pkg::ST_OUT:   out_valid   = 1'b1;
            default:           in_ready    = 1'b0;
        endcase
        cmd.in_take  = in_ready & in_valid;
        cmd.out_take = out_valid & out_ready;
    end

endmodule

[sv/brb_datapath.sv]
// ----------------------------------------------------------------------------
// brb_datapath
// Pointers, run tracking, size reporting and the byte store
// ----------------------------------------------------------------------------
module brb_datapath #(
    parameter int MAX_BURST = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  brb_pkg::brb_cmd_t  cmd,
    output brb_pkg::brb_stat_t stat,
    input  logic [2:0]        action,
    input  logic [7:0]        data_byte,
    input  logic [11:0]       length,
    input  logic              first_of_run,
    output logic [7:0]        out_byte,
    output logic [11:0]       moved_count,
    output logic              status,
    output logic [11:0]       used_bytes,
    output logic [11:0]       free_bytes,
    output logic [12:0]       contiguous_write,
    output logic [11:0]       contiguous_read,
    output logic              last
);

    localparam int PW    = brb_pkg::BRB_PTR_W;
    localparam int LW    = brb_pkg::BRB_LEN_W;
    localparam int CNT_W = $clog2(MAX_BURST + 1);

    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [LW-1:0]    run_rem_reg, run_rem_next;
    logic             run_rej_reg, run_rej_next;
    logic [PW-1:0]    wipe_addr_reg, wipe_addr_next;
    logic [PW-1:0]    rd_addr_reg, rd_addr_next;
    logic [CNT_W-1:0] beats_reg, beats_next;
    logic             show_reg, show_next;
    logic [LW-1:0]    moved_reg, moved_next;
    logic             status_reg, status_next;

    logic [LW-1:0]    used_cur;
    logic [LW-1:0]    free_cur;
    logic [LW-1:0]    len_cap;
    logic [CNT_W-1:0] burst_n;
    logic             ram_we;
    logic [PW-1:0]    ram_waddr;
    logic [7:0]       ram_wdata;
    logic [7:0]       ram_rdata;

    // occupancy from the pointers
    assign used_cur = LW'(wr_ptr_reg - rd_ptr_reg);
    assign free_cur = LW'(brb_pkg::BRB_DEPTH - 1) - used_cur;

    // burst size: min of request, burst limit and bytes held
    always_comb
    begin
        len_cap = (length > LW'(MAX_BURST)) ? LW'(MAX_BURST) : length;
        burst_n = (len_cap > used_cur) ? CNT_W'(used_cur) : CNT_W'(len_cap);
    end

    // status to controller
    assign stat.burst_start = ((action == brb_pkg::ACT_DEQ) || (action == brb_pkg::ACT_PEEK))
                              && (burst_n != '0);
    assign stat.clear_req   = (action == brb_pkg::ACT_CLEAR);
    assign stat.wipe_done   = (wipe_addr_reg == {PW{1'b1}});
    assign stat.burst_more  = (beats_reg > CNT_W'(1));

    // next-state logic for pointers, run state and the result beat
    always_comb
    begin
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        run_rem_next   = run_rem_reg;
        run_rej_next   = run_rej_reg;
        wipe_addr_next = wipe_addr_reg;
        rd_addr_next   = rd_addr_reg;
        beats_next     = beats_reg;
        show_next      = show_reg;
        moved_next     = moved_reg;
        status_next    = status_reg;
        ram_we         = 1'b0;
        ram_waddr      = wr_ptr_reg;
        ram_wdata      = data_byte;

        // fill sweep
        if (cmd.wipe_en)
        begin
            ram_we         = 1'b1;
            ram_waddr      = wipe_addr_reg;
            ram_wdata      = brb_pkg::BRB_FILL;
            wipe_addr_next = wipe_addr_reg + 1'b1;
        end

        // new item
        if (cmd.in_take)
        begin
            beats_next  = '0;
            show_next   = 1'b0;
            moved_next  = '0;
            status_next = 1'b0;
            case (action)
                brb_pkg::ACT_ENQ:
                begin
                    if (first_of_run)
                    begin
                        if (length == '0)
                        begin
                            run_rem_next = '0;
                            run_rej_next = 1'b0;
                        end
                        else if (length > free_cur)
                        begin
                            run_rej_next = 1'b1;
                            run_rem_next = length - 1'b1;
                            status_next  = 1'b1;
                        end
                        else
                        begin
                            run_rej_next = 1'b0;
                            run_rem_next = length - 1'b1;
                            ram_we       = 1'b1;
                            wr_ptr_next  = wr_ptr_reg + 1'b1;
                            moved_next   = length;
                        end
                    end
                    else if (run_rem_reg != '0)
                    begin
                        run_rem_next = run_rem_reg - 1'b1;
                        if (run_rej_reg)
                        begin
                            status_next = 1'b1;
                        end
                        else if (free_cur != '0)
                        begin
                            ram_we      = 1'b1;
                            wr_ptr_next = wr_ptr_reg + 1'b1;
                            moved_next  = LW'(1);
                        end
                    end
                end
                brb_pkg::ACT_DEQ, brb_pkg::ACT_PEEK:
                begin
                    rd_addr_next = rd_ptr_reg;
                    beats_next   = burst_n;
                    show_next    = (burst_n != '0);
                    moved_next   = LW'(burst_n);
                    if (action == brb_pkg::ACT_DEQ)
                    begin
                        rd_ptr_next = rd_ptr_reg + PW'(burst_n);
                    end
                end
                brb_pkg::ACT_MOVE_RD:
                begin
                    rd_ptr_next = rd_ptr_reg + PW'(length);
                end
                brb_pkg::ACT_MOVE_WR:
                begin
                    wr_ptr_next = wr_ptr_reg + PW'(length);
                end
                brb_pkg::ACT_CLEAR:
                begin
                    rd_ptr_next  = '0;
                    wr_ptr_next  = '0;
                    run_rem_next = '0;
                    run_rej_next = 1'b0;
                end
                default:
                begin
                    // query and unused codes: sizes only
                    show_next = 1'b0;
                end
            endcase
        end

        // beat taken: step to the next burst byte
        if (cmd.out_take && (beats_reg != '0))
        begin
            beats_next   = beats_reg - 1'b1;
            rd_addr_next = rd_addr_reg + 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            run_rem_reg   <= '0;
            run_rej_reg   <= 1'b0;
            wipe_addr_reg <= '0;
            beats_reg     <= '0;
            show_reg      <= 1'b0;
        end
        else
        begin
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            run_rem_reg   <= run_rem_next;
            run_rej_reg   <= run_rej_next;
            wipe_addr_reg <= wipe_addr_next;
            beats_reg     <= beats_next;
            show_reg      <= show_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr_next;
        moved_reg   <= moved_next;
        status_reg  <= status_next;
    end

    // byte store
    brb_ram #(
        .WIDTH (brb_pkg::BRB_BYTE_W),
        .DEPTH (brb_pkg::BRB_DEPTH)
    ) u_brb_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    // result fields; sizes follow the pointers, which hold while a beat waits
    always_comb
    begin
        out_byte    = show_reg ? ram_rdata : 8'h00;
        moved_count = moved_reg;
        status      = status_reg;
        last        = (beats_reg <= CNT_W'(1));
        used_bytes  = used_cur;
        free_bytes  = free_cur;
        if (free_cur == '0)
        begin
            contiguous_write = '0;
        end
        else if (rd_ptr_reg <= wr_ptr_reg)
        begin
            contiguous_write = 13'(brb_pkg::BRB_DEPTH) - 13'(wr_ptr_reg);
        end
        else
        begin
            contiguous_write = 13'(rd_ptr_reg - wr_ptr_reg - 1'b1);
        end
        if (rd_ptr_reg <= wr_ptr_reg)
        begin
            contiguous_read = 12'(wr_ptr_reg - rd_ptr_reg);
        end
        else
        begin
            contiguous_read = 12'(13'(brb_pkg::BRB_DEPTH) - 13'(rd_ptr_reg));
        end
    end

endmodule

[sv/byte_ring_buffer_top.sv]
// ----------------------------------------------------------------------------
// byte_ring_buffer_top
// Circular byte fifo of 4096 slots with run enqueue and burst dequeue/peek
// ----------------------------------------------------------------------------
// One item is worked at a time. Enqueue, move, query and empty reads go
// from accept straight to the result beat. A dequeue or peek of n bytes
// gives n beats, since every byte is one registered read of the store
// followed by its beat. After reset, and after every clear, a fill sweep
// writes spaces to all 4096 slots, one per cycle, so the block takes no
// item until the sweep ends; a clear's result beat comes out once its
// sweep ends. At most 4095 bytes are held.
module byte_ring_buffer_top #(
    parameter int MAX_BURST = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic [7:0]  data_byte,
    input  logic [11:0] length,
    input  logic        first_of_run,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic [11:0] moved_count,
    output logic        status,
    output logic [11:0] used_bytes,
    output logic [11:0] free_bytes,
    output logic [12:0] contiguous_write,
    output logic [11:0] contiguous_read,
    output logic        last
);

    brb_pkg::brb_cmd_t  cmd;
    brb_pkg::brb_stat_t stat;

    // controller
    brb_ctrl u_brb_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath
    brb_datapath #(
        .MAX_BURST (MAX_BURST)
    ) u_brb_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .action           (action),
        .data_byte        (data_byte),
        .length           (length),
        .first_of_run     (first_of_run),
        .out_byte         (out_byte),
        .moved_count      (moved_count),
        .status           (status),
        .used_bytes       (used_bytes),
        .free_bytes       (free_bytes),
        .contiguous_write (contiguous_write),
        .contiguous_read  (contiguous_read),
        .last             (last)
    );

endmodule

[sv/brb_checker.sv]
// ----------------------------------------------------------------------------
// brb_checker
// Port-level checks of the circular byte fifo, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [2:0]  action,
    input logic [7:0]  data_byte,
    input logic [11:0] length,
    input logic        first_of_run,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_byte,
    input logic [11:0] moved_count,
    input logic        status,
    input logic [11:0] used_bytes,
    input logic [11:0] free_bytes,
    input logic [12:0] contiguous_write,
    input logic [11:0] contiguous_read,
    input logic        last
);

    // used and free always add up to one less than the store
    `BRB_ASSERT_SAME(a_size_sum, out_valid, (13'(used_bytes) + 13'(free_bytes)) == 13'd4095, "used plus free is not 4095")

    // no new item while a beat is pending
    `BRB_ASSERT_SAME(a_one_item, out_valid, !in_ready, "input taken while a beat waits")

    // contiguous readable span never exceeds what is held
    `BRB_ASSERT_SAME(a_cr_bound, out_valid, contiguous_read <= used_bytes, "contiguous read above used")

    // a burst keeps going until its last beat
    `BRB_ASSERT_NEXT(a_burst_cont, out_valid && out_ready && !last, !in_ready, "burst cut short")

    // a stalled beat holds its byte
    `BRB_ASSERT_NEXT(a_hold_byte, out_valid && !out_ready, out_valid && $stable(out_byte), "stalled beat changed")

endmodule

bind byte_ring_buffer_top brb_checker u_brb_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the circular byte fifo (byte_ring_buffer_top)
// ----------------------------------------------------------------------------
// A queue of pending requests feeds a valid/ready driver. A shadow copy of the
// store and pointers predicts every result beat when a request is accepted.
// The monitor compares each accepted beat field by field with the oldest
// prediction. A directed pass covers the corner cases. Random runs, bursts,
// pointer moves and clears follow, with idle cycles on both sides and a long
// receiver hold.
// ----------------------------------------------------------------------------
module testbench;

    localparam int BURST_LIMIT = 64;
    localparam int QUIET_LIMIT = 20000;
    localparam logic [2:0] ACT_UNUSED = 3'd7;

    typedef struct {
        logic [2:0]  act;
        logic [7:0]  dat;
        logic [11:0] len;
        logic        first;
        bit          drain;
    } fifo_req_t;

    typedef struct {
        logic [7:0]  rd_byte;
        logic [11:0] moved;
        logic        refused;
        logic [11:0] used_n;
        logic [11:0] free_n;
        logic [12:0] cont_wr;
        logic [11:0] cont_rd;
        logic        is_last;
    } fifo_beat_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  action;
    logic [7:0]  data_byte;
    logic [11:0] length;
    logic        first_of_run;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic [11:0] moved_count;
    logic        status;
    logic [11:0] used_bytes;
    logic [11:0] free_bytes;
    logic [12:0] contiguous_write;
    logic [11:0] contiguous_read;
    logic        last;

    // shadow of the block state
    logic [7:0]  shadow_mem [0:brb_pkg::BRB_DEPTH-1];
    logic [11:0] shadow_rd;
    logic [11:0] shadow_wr;
    logic [11:0] run_left;
    logic        run_refused;

    fifo_req_t  pending_reqs[$];
    fifo_beat_t expected_beats[$];
    fifo_req_t  tx_req;
    fifo_beat_t rx_want;

    int  items_queued;
    int  items_taken;
    int  beats_seen;
    int  errors;
    int  quiet_cycles;
    int  hold_left;
    bit  long_hold_done;
    bit  in_taken;

    byte_ring_buffer_top #(.MAX_BURST(BURST_LIMIT)) uut (.*);

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int shadow_used();
        logic [11:0] diff;
        diff = shadow_wr - shadow_rd;
        return int'(diff);
    endfunction

    function automatic int shadow_free();
        return brb_pkg::BRB_DEPTH - 1 - shadow_used();
    endfunction

    function automatic void wipe_shadow();
        for (int k = 0; k < brb_pkg::BRB_DEPTH; k++)
            shadow_mem[k] = brb_pkg::BRB_FILL;
        shadow_rd   = '0;
        shadow_wr   = '0;
        run_left    = '0;
        run_refused = 1'b0;
    endfunction

    function automatic void put_byte(logic [7:0] b);
        shadow_mem[shadow_wr] = b;
        shadow_wr = shadow_wr + 12'd1;
    endfunction

    // one expected beat, sizes taken from the state after the request
    function automatic void push_beat(logic [7:0] b, logic [11:0] moved,
                                      logic refused, logic is_last);
        fifo_beat_t beat;
        int cw;
        int cr;
        if (shadow_free() == 0)
            cw = 0;
        else if (shadow_rd <= shadow_wr)
            cw = brb_pkg::BRB_DEPTH - int'(shadow_wr);
        else
            cw = int'(shadow_rd) - int'(shadow_wr) - 1;
        if (shadow_rd <= shadow_wr)
            cr = int'(shadow_wr) - int'(shadow_rd);
        else
            cr = brb_pkg::BRB_DEPTH - int'(shadow_rd);
        beat.rd_byte = b;
        beat.moved   = moved;
        beat.refused = refused;
        beat.used_n  = 12'(shadow_used());
        beat.free_n  = 12'(shadow_free());
        beat.cont_wr = cw[12:0];
        beat.cont_rd = cr[11:0];
        beat.is_last = is_last;
        expected_beats.push_back(beat);
    endfunction

    // advance the shadow by one request and queue its result beats
    function automatic void predict_fifo_op(logic [2:0] act, logic [7:0] dat,
                                            logic [11:0] len, logic first);
        logic [11:0] moved;
        logic        refused;
        logic [11:0] start;
        logic [11:0] addr;
        int          n;
        moved   = '0;
        refused = 1'b0;
        case (act)
            brb_pkg::ACT_ENQ:
            begin
                if (first)
                begin
                    if (len == 12'd0)
                    begin
                        run_left    = '0;
                        run_refused = 1'b0;
                    end
                    else if (int'(len) > shadow_free())
                    begin
                        run_refused = 1'b1;
                        run_left    = len - 12'd1;
                        refused     = 1'b1;
                    end
                    else
                    begin
                        run_refused = 1'b0;
                        run_left    = len - 12'd1;
                        put_byte(dat);
                        moved = len;
                    end
                end
                else if (run_left != 12'd0)
                begin
                    run_left = run_left - 12'd1;
                    if (run_refused)
                        refused = 1'b1;
                    else if (shadow_free() != 0)
                    begin
                        put_byte(dat);
                        moved = 12'd1;
                    end
                end
                push_beat(8'd0, moved, refused, 1'b1);
            end
            brb_pkg::ACT_DEQ, brb_pkg::ACT_PEEK:
            begin
                n = int'(len);
                if (n > BURST_LIMIT)
                    n = BURST_LIMIT;
                if (n > shadow_used())
                    n = shadow_used();
                start = shadow_rd;
                if (act == brb_pkg::ACT_DEQ)
                    shadow_rd = shadow_rd + n[11:0];
                if (n == 0)
                    push_beat(8'd0, 12'd0, 1'b0, 1'b1);
                for (int k = 0; k < n; k++)
                begin
                    addr = start + k[11:0];
                    push_beat(shadow_mem[addr], n[11:0], 1'b0, k == n - 1);
                end
            end
            default:
            begin
                if (act == brb_pkg::ACT_MOVE_RD)
                    shadow_rd = shadow_rd + len;
                else if (act == brb_pkg::ACT_MOVE_WR)
                    shadow_wr = shadow_wr + len;
                else if (act == brb_pkg::ACT_CLEAR)
                    wipe_shadow();
                push_beat(8'd0, 12'd0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    task automatic add_item(logic [2:0] act, logic [7:0] dat, logic [11:0] len,
                            logic first, bit drain = 1'b0);
        fifo_req_t req;
        req.act   = act;
        req.dat   = dat;
        req.len   = len;
        req.first = first;
        req.drain = drain;
        pending_reqs.push_back(req);
        items_queued++;
    endtask

    // dequeue or peek count: mostly short, with zero, full burst and clamped
    function automatic logic [11:0] pick_count();
        case ($urandom_range(9))
            0: return 12'd0;
            1: return 12'd64;
            2: return 12'($urandom_range(65, 4095));
            default: return 12'($urandom_range(1, 20));
        endcase
    endfunction

    task automatic fill_random(int target);
        int pick;
        int run_len;
        int hop;
        while (items_queued < target)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                // well-formed run, sometimes cut short or interleaved
                run_len = ($urandom_range(7) == 0) ? $urandom_range(13, 80)
                                                   : $urandom_range(1, 12);
                add_item(brb_pkg::ACT_ENQ, 8'($urandom_range(255)), 12'(run_len), 1'b1);
                for (int k = 1; k < run_len; k++)
                begin
                    if ($urandom_range(24) == 0)
                        break;
                    if ($urandom_range(14) == 0)
                        add_item($urandom_range(1) ? brb_pkg::ACT_QUERY : brb_pkg::ACT_PEEK,
                                 8'($urandom_range(255)), 12'($urandom_range(4)), 1'b0);
                    add_item(brb_pkg::ACT_ENQ, 8'($urandom_range(255)),
                             12'($urandom_range(4095)), 1'b0);
                end
            end
            else if (pick < 60)
            begin
                add_item(brb_pkg::ACT_DEQ, 8'($urandom_range(255)), pick_count(),
                         1'($urandom_range(1)));
            end
            else if (pick < 72)
            begin
                add_item(brb_pkg::ACT_PEEK, 8'($urandom_range(255)), pick_count(),
                         1'($urandom_range(1)));
            end
            else if (pick < 82)
            begin
                // skip ahead on the write side, then catch up on the read side
                hop = $urandom_range(40);
                add_item(brb_pkg::ACT_MOVE_WR, 8'($urandom_range(255)), 12'(hop),
                         1'($urandom_range(1)));
                add_item(brb_pkg::ACT_PEEK, 8'($urandom_range(255)), pick_count(), 1'b0);
                add_item(brb_pkg::ACT_MOVE_RD, 8'($urandom_range(255)), 12'(hop),
                         1'($urandom_range(1)));
            end
            else if (pick < 92)
            begin
                add_item($urandom_range(1) ? brb_pkg::ACT_QUERY : ACT_UNUSED,
                         8'($urandom_range(255)), 12'($urandom_range(4095)),
                         1'($urandom_range(1)));
            end
            else if (pick < 96)
            begin
                // stray bytes and oversized runs
                if ($urandom_range(1))
                    add_item(brb_pkg::ACT_ENQ, 8'($urandom_range(255)),
                             12'($urandom_range(4095)), 1'b0);
                else
                begin
                    add_item(brb_pkg::ACT_ENQ, 8'($urandom_range(255)),
                             12'($urandom_range(4095)), 1'b1);
                    add_item(brb_pkg::ACT_ENQ, 8'($urandom_range(255)),
                             12'($urandom_range(4095)), 1'b0);
                    add_item(brb_pkg::ACT_ENQ, 8'($urandom_range(255)),
                             12'($urandom_range(4095)), 1'b0);
                end
            end
            else
            begin
                // wild pointer move, work on the odd state, then clear
                add_item($urandom_range(1) ? brb_pkg::ACT_MOVE_RD : brb_pkg::ACT_MOVE_WR,
                         8'($urandom_range(255)), 12'($urandom_range(4095)), 1'b0);
                add_item(brb_pkg::ACT_DEQ, 8'($urandom_range(255)), 12'd64, 1'b0);
                add_item(brb_pkg::ACT_ENQ, 8'($urandom_range(255)),
                         12'($urandom_range(1, 6)), 1'b1);
                add_item(brb_pkg::ACT_ENQ, 8'($urandom_range(255)), 12'd0, 1'b0);
                add_item(brb_pkg::ACT_CLEAR, 8'($urandom_range(255)),
                         12'($urandom_range(4095)), 1'b0);
            end
        end
    endtask

    function automatic int tx_idle_pct();
        return (items_taken >= 140 && items_taken < 200) ? 0 : 35;
    endfunction

    function automatic int rx_idle_pct();
        return (beats_seen >= 100 && beats_seen < 220) ? 0 : 35;
    endfunction

    function automatic void check_field(string what, logic [12:0] want,
                                        logic [12:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            errors++;
        end
    endfunction

    // request beat accepted: predict its results
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            predict_fifo_op(action, data_byte, length, first_of_run);
            items_taken++;
            in_taken = 1'b1;
        end
    end

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            in_taken = 1'b0;
            if (pending_reqs.size() != 0
                && !(pending_reqs[0].drain && expected_beats.size() != 0)
                && $urandom_range(99) >= tx_idle_pct())
            begin
                tx_req = pending_reqs.pop_front();
                action       <= tx_req.act;
                data_byte    <= tx_req.dat;
                length       <= tx_req.len;
                first_of_run <= tx_req.first;
                in_valid     <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result ready, with one long hold while requests keep coming
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (!long_hold_done && beats_seen >= 250)
        begin
            long_hold_done = 1'b1;
            hold_left = 400;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct());
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            beats_seen++;
            if (expected_beats.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, out_byte %0d",
                         $time, out_byte);
                errors++;
            end
            else
            begin
                rx_want = expected_beats.pop_front();
                check_field("out_byte", 13'(rx_want.rd_byte), 13'(out_byte));
                check_field("moved_count", 13'(rx_want.moved), 13'(moved_count));
                check_field("status", 13'(rx_want.refused), 13'(status));
                check_field("used_bytes", 13'(rx_want.used_n), 13'(used_bytes));
                check_field("free_bytes", 13'(rx_want.free_n), 13'(free_bytes));
                check_field("contiguous_write", rx_want.cont_wr, contiguous_write);
                check_field("contiguous_read", 13'(rx_want.cont_rd), 13'(contiguous_read));
                check_field("last", 13'(rx_want.is_last), 13'(last));
            end
        end
    end

    // cycles without any accepted beat
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        out_ready      = 1'b0;
        action         = brb_pkg::ACT_QUERY;
        data_byte      = 8'd0;
        length         = 12'd0;
        first_of_run   = 1'b0;
        items_queued   = 0;
        items_taken    = 0;
        beats_seen     = 0;
        errors         = 0;
        quiet_cycles   = 0;
        hold_left      = 0;
        long_hold_done = 1'b0;
        in_taken       = 1'b0;
        wipe_shadow();

        // directed corner cases
        add_item(brb_pkg::ACT_QUERY, 8'h00, 12'd0, 1'b0);
        add_item(brb_pkg::ACT_DEQ, 8'hFF, 12'd5, 1'b1);        // empty dequeue
        add_item(brb_pkg::ACT_PEEK, 8'h00, 12'd0, 1'b0);       // zero-count peek
        add_item(brb_pkg::ACT_ENQ, 8'h00, 12'd3, 1'b1);
        add_item(brb_pkg::ACT_ENQ, 8'hFF, 12'd0, 1'b0);
        add_item(brb_pkg::ACT_ENQ, 8'hA5, 12'd0, 1'b0);
        add_item(brb_pkg::ACT_ENQ, 8'h5A, 12'd0, 1'b0);        // stray byte
        add_item(brb_pkg::ACT_PEEK, 8'h00, 12'd64, 1'b0);
        add_item(brb_pkg::ACT_DEQ, 8'h00, 12'd4095, 1'b0);
        add_item(brb_pkg::ACT_ENQ, 8'h77, 12'd0, 1'b1);        // zero-length run
        add_item(brb_pkg::ACT_ENQ, 8'h78, 12'd9, 1'b0);
        add_item(brb_pkg::ACT_MOVE_WR, 8'h00, 12'd4090, 1'b0); // five slots left
        add_item(brb_pkg::ACT_ENQ, 8'h99, 12'd4095, 1'b1);     // run refused
        add_item(brb_pkg::ACT_ENQ, 8'h9A, 12'd0, 1'b0);
        add_item(brb_pkg::ACT_ENQ, 8'h11, 12'd2, 1'b1);        // new run replaces old one
        add_item(brb_pkg::ACT_QUERY, 8'h00, 12'd0, 1'b0);      // other action mid-run
        add_item(brb_pkg::ACT_ENQ, 8'h22, 12'd0, 1'b0);
        add_item(brb_pkg::ACT_ENQ, 8'h33, 12'd3, 1'b1);        // wraps the write side
        add_item(brb_pkg::ACT_MOVE_WR, 8'h00, 12'd2, 1'b0);    // store now full
        add_item(brb_pkg::ACT_ENQ, 8'h44, 12'd0, 1'b0);        // dropped bytes
        add_item(brb_pkg::ACT_ENQ, 8'h55, 12'd0, 1'b0);
        add_item(brb_pkg::ACT_PEEK, 8'h00, 12'd64, 1'b0);
        add_item(brb_pkg::ACT_DEQ, 8'h00, 12'd100, 1'b0);
        add_item(brb_pkg::ACT_MOVE_RD, 8'h00, 12'd4095, 1'b0);
        add_item(ACT_UNUSED, 8'hFF, 12'd4095, 1'b1);
        add_item(brb_pkg::ACT_CLEAR, 8'h00, 12'd0, 1'b0, 1'b1);
        add_item(brb_pkg::ACT_QUERY, 8'h00, 12'd0, 1'b0);

        // random traffic, with one full drain half way
        fill_random(135);
        add_item(brb_pkg::ACT_QUERY, 8'h00, 12'd0, 1'b0, 1'b1);
        fill_random(265);

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        wait (items_taken == items_queued);
        wait (expected_beats.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_beats.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
